[design/sorted_event_timer_queue_assert.svh]
// ----------------------------------------------------------------------------
// Sorted event timer queue assertion macros
// Clocked implication forms used by the block's checker.
// ----------------------------------------------------------------------------
`ifndef SORTED_EVENT_TIMER_QUEUE_ASSERT_SVH
`define SORTED_EVENT_TIMER_QUEUE_ASSERT_SVH

// same-cycle implication
`define SETQ_ASSERT_IMP(name, clk, rst, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define SETQ_ASSERT_NXT(name, clk, rst, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[design/setq_pkg.sv]
// ----------------------------------------------------------------------------
// Sorted event timer queue package
// Sizes, field widths, codes and shared types of the timer queue.
// ----------------------------------------------------------------------------
package setq_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int TAG_WIDTH   = 16;
  localparam int IDX_W       = $clog2(QUEUE_DEPTH);
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

  localparam int W_OP     = 2;
  localparam int W_NOW_S  = 31;
  localparam int W_HOUR   = 5;
  localparam int W_MINSEC = 6;
  localparam int W_TGT    = 6;
  localparam int W_TAG    = 16;
  localparam int W_POS    = 8;
  localparam int W_STATUS = 3;
  localparam int W_TIME   = 32;
  localparam int W_COUNT  = 5;

  localparam int SEC_PER_HOUR  = 3600;
  localparam int SEC_PER_MIN   = 60;
  localparam int HOURS_PER_DAY = 24;
  localparam int MIN_PER_HOUR  = 60;
  localparam int MAX_HOUR      = 23;
  localparam int MAX_MINUTE    = 59;
  localparam int PM_HOURS      = 12;

  localparam logic [W_OP-1:0] OP_INSERT = 2'd0;
  localparam logic [W_OP-1:0] OP_REMOVE = 2'd1;
  localparam logic [W_OP-1:0] OP_TICK   = 2'd2;

  typedef enum logic [W_STATUS-1:0] {
    ST_OK       = 3'd0,
    ST_BAD_TIME = 3'd1,
    ST_REL_PM   = 3'd2,
    ST_FULL     = 3'd3,
    ST_EMPTY    = 3'd4,
    ST_ZERO_POS = 3'd5,
    ST_BAD_POS  = 3'd6
  } status_t;

  typedef logic [TAG_WIDTH-1:0] tag_t;
  typedef logic [IDX_W-1:0]     idx_t;

  typedef struct packed {
    logic [W_TIME-1:0] due;
    tag_t              tag;
  } entry_t;

  typedef struct packed {
    logic                we;
    idx_t                waddr;
    entry_t              wdata;
    logic                re;
    idx_t                raddr;
  } store_req_t;

  typedef struct packed {
    logic [W_NOW_S-1:0]  now_seconds;
    logic [W_HOUR-1:0]   now_hour;
    logic [W_MINSEC-1:0] now_minute;
    logic [W_MINSEC-1:0] now_second;
    logic [W_TGT-1:0]    target_hour;
    logic [W_TGT-1:0]    target_minute;
    logic                pm_flag;
    logic                relative_flag;
  } calc_req_t;

endpackage

[design/setq_in_if.sv]
// ----------------------------------------------------------------------------
// Sorted event timer queue command channel
// Valid/ready channel carrying one command beat.
// ----------------------------------------------------------------------------
interface setq_in_if import setq_pkg::*;;
  logic                valid;
  logic                ready;
  logic [W_OP-1:0]     operation;
  logic [W_NOW_S-1:0]  now_seconds;
  logic [W_HOUR-1:0]   now_hour;
  logic [W_MINSEC-1:0] now_minute;
  logic [W_MINSEC-1:0] now_second;
  logic [W_TGT-1:0]    target_hour;
  logic [W_TGT-1:0]    target_minute;
  logic                pm_flag;
  logic                relative_flag;
  logic [W_TAG-1:0]    event_tag;
  logic [W_POS-1:0]    remove_position;

  modport source (
    output valid, operation, now_seconds, now_hour, now_minute, now_second,
           target_hour, target_minute, pm_flag, relative_flag, event_tag,
           remove_position,
    input  ready
  );
  modport sink (
    input  valid, operation, now_seconds, now_hour, now_minute, now_second,
           target_hour, target_minute, pm_flag, relative_flag, event_tag,
           remove_position,
    output ready
  );
endinterface

[design/setq_out_if.sv]
// ----------------------------------------------------------------------------
// Sorted event timer queue result channel
// Valid/ready channel carrying one result beat.
// ----------------------------------------------------------------------------
interface setq_out_if import setq_pkg::*;;
  logic                valid;
  logic                ready;
  logic [W_STATUS-1:0] status;
  logic                fired;
  logic [W_TAG-1:0]    fired_tag;
  logic [W_TIME-1:0]   fired_time;
  logic                last;
  logic [W_COUNT-1:0]  queue_count;
  logic                queue_empty;
  logic [W_TIME-1:0]   next_due;

  modport source (
    output valid, status, fired, fired_tag, fired_time, last, queue_count,
           queue_empty, next_due,
    input  ready
  );
  modport sink (
    input  valid, status, fired, fired_tag, fired_time, last, queue_count,
           queue_empty, next_due,
    output ready
  );
endinterface

[design/setq_due_calc.sv]
// ----------------------------------------------------------------------------
// Sorted event timer queue due time unit
// Three-stage pipe turning an hour:minute target into a due second.
// ----------------------------------------------------------------------------
module setq_due_calc import setq_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  calc_req_t         calc,
  output logic              done,
  output logic [W_TIME-1:0] due
);

  logic                     v1, v2, v3;
  logic signed [7:0]        dh, dm;
  logic signed [7:0]        dh_next, dm_next;
  logic [W_TIME-1:0]        base, base2;
  logic [W_TIME-1:0]        hsec, msec;

  logic [W_TGT-1:0]         hr6;
  logic signed [7:0]        hr_s, nh_s, mi_s, nm_s, dh0, dh1, dh2, dm0;

  always_comb begin
    hr6  = calc.pm_flag ? calc.target_hour + W_TGT'(PM_HOURS) : calc.target_hour;
    hr_s = signed'({2'b00, hr6});
    nh_s = signed'({3'b000, calc.now_hour});
    mi_s = signed'({2'b00, calc.target_minute});
    nm_s = signed'({2'b00, calc.now_minute});
    dh0  = hr_s - nh_s;
    dh1  = (dh0 < 8'sd0) ? dh0 + 8'(HOURS_PER_DAY) : dh0;
    dm0  = mi_s - nm_s;
    dh2  = dh1;
    dm_next = dm0;
    if (dm0 < 8'sd0) begin
      dm_next = dm0 + 8'(MIN_PER_HOUR);
      dh2     = dh1 - 8'sd1;
      if (dh2 < 8'sd0) begin
        dh2 = 8'(MAX_HOUR);
      end
    end
    dh_next = dh2;
    if (calc.relative_flag) begin
      dh_next = hr_s;
      dm_next = mi_s;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      v1 <= start;
      v2 <= v1;
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dh   <= dh_next;
      dm   <= dm_next;
      base <= W_TIME'(calc.now_seconds) - W_TIME'(calc.now_second);
    end
    if (v1) begin
      hsec  <= W_TIME'(32'(dh) * 32'(SEC_PER_HOUR));
      msec  <= W_TIME'(32'(dm) * 32'(SEC_PER_MIN));
      base2 <= base;
    end
    if (v2) begin
      due <= base2 + hsec + msec;
    end
  end

  assign done = v3;

endmodule

[design/setq_store.sv]
// ----------------------------------------------------------------------------
// Sorted event timer queue entry store
// One-write one-read entry memory with a registered read and a head copy.
// ----------------------------------------------------------------------------
module setq_store import setq_pkg::*; (
  input  logic       clk,
  input  store_req_t req,
  output entry_t     rd_data,
  output entry_t     head
);

  entry_t mem [QUEUE_DEPTH];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    if (req.re) begin
      rd_data <= mem[req.raddr];
    end
    if (req.we && req.waddr == '0) begin
      head <= req.wdata;
    end
  end

endmodule

[design/sorted_event_timer_queue.sv]
// ----------------------------------------------------------------------------
// Sorted event timer queue
// Holds up to QUEUE_DEPTH timed events sorted by due second; insert, remove
// by position and tick expiry share one compare and the one-write one-read store.
// ----------------------------------------------------------------------------
// Usage:
//   req carries one command beat (insert, remove, tick); rsp returns result
//   beats, one per command except a tick, which returns one beat per expired
//   event (last marks the final beat), or one empty beat if nothing is due.
//   req.ready is high only while the sequencer is idle; one command at a time.
// Sequencing, with the walk over the entry memory moving one entry per cycle:
//   insert: due time pipe, then up to held_count walk steps plus one
//     placement step before the result beat.
//   remove: shifts the entries behind the position down by one slot.
//   tick: shifts the remaining entries down once per expired event.
//   Errors and unknown operations: straight to the result beat.
// A result waits in the rsp register while the receiver stalls; the block
// may take the next command meanwhile, and holds later beats until it drains.
// Reset empties the queue at once; no clearing pass is made.
// ----------------------------------------------------------------------------
module sorted_event_timer_queue import setq_pkg::*; (
  input logic        clk,
  input logic        rst,
  setq_in_if.sink    req,
  setq_out_if.source rsp
);

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_CALC  = 7'b0000010,
    S_WALK  = 7'b0000100,
    S_PUT   = 7'b0001000,
    S_TICK  = 7'b0010000,
    S_SHIFT = 7'b0100000,
    S_EMIT  = 7'b1000000
  } state_t;

  state_t            state, state_next;
  logic [CNT_W-1:0]  count, count_next;
  idx_t              idx, idx_next;
  tag_t              tag_q;
  logic [W_NOW_S-1:0] now_q;
  status_t           res_status, res_status_next;
  logic              res_fired, res_fired_next;
  tag_t              res_tag, res_tag_next;
  logic [W_TIME-1:0] res_time, res_time_next;

  logic              accept, calc_start, calc_done, load, more, cmp_gt;
  logic [W_TIME-1:0] calc_due, cmp_a, cmp_b;
  calc_req_t         calc;
  store_req_t        sreq;
  entry_t            rd_data, head, new_ent;

  assign req.ready = (state == S_IDLE);
  assign accept    = req.valid && req.ready;

  assign calc.now_seconds   = req.now_seconds;
  assign calc.now_hour      = req.now_hour;
  assign calc.now_minute    = req.now_minute;
  assign calc.now_second    = req.now_second;
  assign calc.target_hour   = req.target_hour;
  assign calc.target_minute = req.target_minute;
  assign calc.pm_flag       = req.pm_flag;
  assign calc.relative_flag = req.relative_flag;

  setq_due_calc u_calc (
    .clk   (clk),
    .rst   (rst),
    .start (calc_start),
    .calc  (calc),
    .done  (calc_done),
    .due   (calc_due)
  );

  setq_store u_store (
    .clk     (clk),
    .req     (sreq),
    .rd_data (rd_data),
    .head    (head)
  );

  assign new_ent = '{due: calc_due, tag: tag_q};

  assign cmp_a  = (state == S_WALK) ? rd_data.due : W_TIME'(now_q);
  assign cmp_b  = (state == S_WALK) ? calc_due : head.due;
  assign cmp_gt = cmp_a > cmp_b;
  assign more   = (count != '0) && cmp_gt;
  assign load   = (state == S_EMIT) && (!rsp.valid || rsp.ready);

  always_comb begin
    state_next      = state;
    count_next      = count;
    idx_next        = idx;
    res_status_next = res_status;
    res_fired_next  = res_fired;
    res_tag_next    = res_tag;
    res_time_next   = res_time;
    calc_start      = 1'b0;
    sreq            = '0;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          res_status_next = ST_OK;
          res_fired_next  = 1'b0;
          res_tag_next    = '0;
          res_time_next   = '0;
          state_next      = S_EMIT;
          priority case (req.operation)
            OP_INSERT: begin
              if (32'(req.target_hour) > MAX_HOUR
                  || 32'(req.target_minute) > MAX_MINUTE) begin
                res_status_next = ST_BAD_TIME;
              end else if (req.pm_flag && req.relative_flag) begin
                res_status_next = ST_REL_PM;
              end else if (count == CNT_W'(QUEUE_DEPTH)) begin
                res_status_next = ST_FULL;
              end else begin
                calc_start = 1'b1;
                state_next = S_CALC;
              end
            end
            OP_REMOVE: begin
              if (count == '0) begin
                res_status_next = ST_EMPTY;
              end else if (req.remove_position == '0) begin
                res_status_next = ST_ZERO_POS;
              end else if (32'(req.remove_position) > 32'(count)) begin
                res_status_next = ST_BAD_POS;
              end else if (32'(req.remove_position) == 32'(count)) begin
                count_next = count - 1'b1;
              end else begin
                sreq.re    = 1'b1;
                sreq.raddr = IDX_W'(req.remove_position);
                idx_next   = IDX_W'(req.remove_position);
                state_next = S_SHIFT;
              end
            end
            OP_TICK: begin
              state_next = S_TICK;
            end
            default: begin
              state_next = S_EMIT;
            end
          endcase
        end
      end
      S_CALC: begin
        if (calc_done) begin
          if (count == '0) begin
            sreq.we    = 1'b1;
            sreq.waddr = '0;
            sreq.wdata = new_ent;
            count_next = count + 1'b1;
            state_next = S_EMIT;
          end else begin
            sreq.re    = 1'b1;
            sreq.raddr = IDX_W'(count - 1'b1);
            idx_next   = IDX_W'(count - 1'b1);
            state_next = S_WALK;
          end
        end
      end
      S_WALK: begin
        sreq.we    = 1'b1;
        sreq.waddr = idx + 1'b1;
        if (cmp_gt) begin
          sreq.wdata = rd_data;
          if (idx == '0) begin
            state_next = S_PUT;
          end else begin
            sreq.re    = 1'b1;
            sreq.raddr = idx - 1'b1;
            idx_next   = idx - 1'b1;
          end
        end else begin
          sreq.wdata = new_ent;
          count_next = count + 1'b1;
          state_next = S_EMIT;
        end
      end
      S_PUT: begin
        sreq.we    = 1'b1;
        sreq.waddr = '0;
        sreq.wdata = new_ent;
        count_next = count + 1'b1;
        state_next = S_EMIT;
      end
      S_TICK: begin
        state_next = S_EMIT;
        if (more) begin
          res_fired_next = 1'b1;
          res_tag_next   = head.tag;
          res_time_next  = head.due;
          if (count == CNT_W'(1)) begin
            count_next = '0;
          end else begin
            sreq.re    = 1'b1;
            sreq.raddr = IDX_W'(1);
            idx_next   = IDX_W'(1);
            state_next = S_SHIFT;
          end
        end
      end
      S_SHIFT: begin
        sreq.we    = 1'b1;
        sreq.waddr = idx - 1'b1;
        sreq.wdata = rd_data;
        if (32'(idx) + 1 < 32'(count)) begin
          sreq.re    = 1'b1;
          sreq.raddr = idx + 1'b1;
          idx_next   = idx + 1'b1;
        end else begin
          count_next = count - 1'b1;
          state_next = S_EMIT;
        end
      end
      S_EMIT: begin
        if (load) begin
          state_next = (res_fired && more) ? S_TICK : S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      rsp.valid <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      if (load) begin
        rsp.valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    idx        <= idx_next;
    res_status <= res_status_next;
    res_fired  <= res_fired_next;
    res_tag    <= res_tag_next;
    res_time   <= res_time_next;
    if (accept) begin
      tag_q <= tag_t'(req.event_tag);
      now_q <= req.now_seconds;
    end
    if (load) begin
      rsp.status      <= res_status;
      rsp.fired       <= res_fired;
      rsp.fired_tag   <= W_TAG'(res_tag);
      rsp.fired_time  <= res_time;
      rsp.last        <= !(res_fired && more);
      rsp.queue_count <= W_COUNT'(count);
      rsp.queue_empty <= (count == '0);
      rsp.next_due    <= (count == '0) ? '1 : head.due;
    end
  end

endmodule

[design/setq_checker.sv]
// ----------------------------------------------------------------------------
// Sorted event timer queue checker
// Port-level checks on result beats, bound to the top level.
// ----------------------------------------------------------------------------
`include "sorted_event_timer_queue_assert.svh"

module setq_checker import setq_pkg::*; (
  input logic                clk,
  input logic                rst,
  input logic                rsp_valid,
  input logic                rsp_ready,
  input logic [W_STATUS-1:0] status,
  input logic                fired,
  input logic [W_TAG-1:0]    fired_tag,
  input logic [W_TIME-1:0]   fired_time,
  input logic                last,
  input logic [W_COUNT-1:0]  queue_count,
  input logic                queue_empty,
  input logic [W_TIME-1:0]   next_due
);

  `SETQ_ASSERT_NXT(a_rsp_hold, clk, rst, rsp_valid && !rsp_ready, rsp_valid && $stable(fired_time) && $stable(queue_count), "result beat dropped or changed while stalled")
  `SETQ_ASSERT_IMP(a_idle_beat, clk, rst, rsp_valid && !fired, fired_tag == '0 && fired_time == '0 && last, "non-fired beat carries event data")
  `SETQ_ASSERT_IMP(a_empty_view, clk, rst, rsp_valid, (queue_empty == (queue_count == '0)) && (!queue_empty || next_due == '1) && (32'(queue_count) <= QUEUE_DEPTH), "queue summary inconsistent")
  `SETQ_ASSERT_IMP(a_fired_order, clk, rst, rsp_valid && fired, status == ST_OK && fired_time <= next_due, "expired event out of order")

endmodule

bind sorted_event_timer_queue setq_checker u_setq_checker (
  .clk         (clk),
  .rst         (rst),
  .rsp_valid   (rsp.valid),
  .rsp_ready   (rsp.ready),
  .status      (rsp.status),
  .fired       (rsp.fired),
  .fired_tag   (rsp.fired_tag),
  .fired_time  (rsp.fired_time),
  .last        (rsp.last),
  .queue_count (rsp.queue_count),
  .queue_empty (rsp.queue_empty),
  .next_due    (rsp.next_due)
);

[tb/tb_sorted_event_timer_queue.sv]
// ----------------------------------------------------------------------------
// Sorted event timer queue testbench
// Drives insert, remove, tick and unused-code commands over the command channel with
// random gaps. Each beat is scored against an in-bench model of the sorted
// queue. The result channel stalls at random, and every result beat is
// checked field by field in order.
// ----------------------------------------------------------------------------
module tb_sorted_event_timer_queue import setq_pkg::*;;

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [W_OP-1:0] OP_UNUSED = 2'd3;
  localparam int RAND_ITEMS  = 400;
  localparam int SEC_PER_DAY = 86400;

  typedef enum int {SEG_FILL, SEG_CHURN, SEG_DRAIN} seg_kind_t;

  typedef struct packed {
    logic [W_OP-1:0]     op;
    logic [W_NOW_S-1:0]  now_s;
    logic [W_HOUR-1:0]   now_h;
    logic [W_MINSEC-1:0] now_m;
    logic [W_MINSEC-1:0] now_sec;
    logic [W_TGT-1:0]    tgt_h;
    logic [W_TGT-1:0]    tgt_m;
    logic                pm;
    logic                rel;
    logic [W_TAG-1:0]    tag;
    logic [W_POS-1:0]    pos;
    logic [3:0]          gap;
  } timer_cmd_t;

  typedef struct packed {
    logic [W_STATUS-1:0] status;
    logic                fired;
    logic [W_TAG-1:0]    tag;
    logic [W_TIME-1:0]   when;
    logic                last;
    logic [W_COUNT-1:0]  count;
    logic                empty;
    logic [W_TIME-1:0]   next_due;
  } report_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  setq_in_if  req_if ();
  setq_out_if rsp_if ();

  sorted_event_timer_queue dut (
    .clk (clk),
    .rst (rst),
    .req (req_if),
    .rsp (rsp_if)
  );

  timer_cmd_t cmd_feed[$];
  timer_cmd_t cur_cmd = '0;
  logic       cmd_valid = 1'b0;
  logic       res_ready = 1'b0;
  entry_t     timers[$];
  report_t    report_q[$];
  logic [W_NOW_S-1:0] sim_now;
  bit         stim_calm = 1'b0;
  bit         failed = 1'b0;
  int         n_cmd_sent = 0;
  int         n_cmd_taken = 0;
  int         n_beats = 0;
  int         beats_seen = 0;
  int         waited = 0;
  int         stall = 0;
  int         n_total = 0;

  assign req_if.valid           = cmd_valid;
  assign req_if.operation       = cur_cmd.op;
  assign req_if.now_seconds     = cur_cmd.now_s;
  assign req_if.now_hour        = cur_cmd.now_h;
  assign req_if.now_minute      = cur_cmd.now_m;
  assign req_if.now_second      = cur_cmd.now_sec;
  assign req_if.target_hour     = cur_cmd.tgt_h;
  assign req_if.target_minute   = cur_cmd.tgt_m;
  assign req_if.pm_flag         = cur_cmd.pm;
  assign req_if.relative_flag   = cur_cmd.rel;
  assign req_if.event_tag       = cur_cmd.tag;
  assign req_if.remove_position = cur_cmd.pos;
  assign rsp_if.ready           = res_ready;

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic int draw_gap();
    return stim_calm ? 0 : $urandom_range(0, 14);
  endfunction

  function automatic timer_cmd_t timed_cmd(logic [W_OP-1:0] op);
    timer_cmd_t c;
    int sod;
    c = '0;
    sod = int'(sim_now % SEC_PER_DAY);
    c.op      = op;
    c.now_s   = sim_now;
    c.now_h   = W_HOUR'(sod / SEC_PER_HOUR);
    c.now_m   = W_MINSEC'((sod / SEC_PER_MIN) % MIN_PER_HOUR);
    c.now_sec = W_MINSEC'(sod % SEC_PER_MIN);
    c.rel     = 1'($urandom_range(0, 1));
    c.pm      = !c.rel && $urandom_range(0, 1);
    if (c.rel) begin
      c.tgt_h = W_TGT'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 23)
                                                   : $urandom_range(0, 2));
    end else begin
      c.tgt_h = W_TGT'(c.pm ? $urandom_range(0, 11) : $urandom_range(0, 23));
    end
    c.tgt_m = W_TGT'($urandom_range(0, 59));
    c.tag   = W_TAG'($urandom);
    c.pos   = W_POS'(($urandom_range(0, 9) == 0) ? $urandom_range(0, 255)
                                                 : $urandom_range(1, 16));
    c.gap   = 4'(draw_gap());
    return c;
  endfunction

  function automatic timer_cmd_t noise_cmd();
    timer_cmd_t c;
    logic [95:0] raw;
    raw = {$urandom, $urandom, $urandom};
    c = timer_cmd_t'(raw[$bits(timer_cmd_t)-1:0]);
    c.op  = W_OP'($urandom_range(0, 3));
    c.gap = 4'(draw_gap());
    return c;
  endfunction

  function automatic void post_report(status_t st, logic fired, logic [W_TAG-1:0] tag,
                                      logic [W_TIME-1:0] when, logic last);
    report_t r;
    r.status   = st;
    r.fired    = fired;
    r.tag      = tag;
    r.when     = when;
    r.last     = last;
    r.count    = W_COUNT'(timers.size());
    r.empty    = (timers.size() == 0);
    r.next_due = (timers.size() == 0) ? '1 : timers[0].due;
    report_q.push_back(r);
  endfunction

  function automatic void apply_timer_cmd(timer_cmd_t c);
    status_t st;
    entry_t  e;
    longint  hrs, mins, dh, dm, when;
    int      p, popped;
    case (c.op)
      OP_INSERT: begin
        hrs  = longint'(c.tgt_h);
        mins = longint'(c.tgt_m);
        if (hrs > MAX_HOUR || mins > MAX_MINUTE) st = ST_BAD_TIME;
        else if (c.pm && c.rel) st = ST_REL_PM;
        else if (timers.size() >= QUEUE_DEPTH) st = ST_FULL;
        else begin
          if (c.pm) hrs += PM_HOURS;
          if (c.rel) begin
            dh = hrs;
            dm = mins;
          end else begin
            dh = hrs - longint'(c.now_h);
            if (dh < 0) dh += HOURS_PER_DAY;
            dm = mins - longint'(c.now_m);
            if (dm < 0) begin
              dm += MIN_PER_HOUR;
              dh -= 1;
              if (dh < 0) dh = MAX_HOUR;
            end
          end
          when = longint'(c.now_s) - longint'(c.now_sec) + dh * SEC_PER_HOUR
               + dm * SEC_PER_MIN;
          e.due = when[W_TIME-1:0];
          e.tag = c.tag[TAG_WIDTH-1:0];
          p = 0;
          while (p < timers.size() && timers[p].due <= e.due) p++;
          timers.insert(p, e);
          st = ST_OK;
        end
        post_report(st, 1'b0, '0, '0, 1'b1);
      end
      OP_REMOVE: begin
        if (timers.size() == 0) st = ST_EMPTY;
        else if (c.pos == 0) st = ST_ZERO_POS;
        else if (c.pos > timers.size()) st = ST_BAD_POS;
        else begin
          timers.delete(c.pos - 1);
          st = ST_OK;
        end
        post_report(st, 1'b0, '0, '0, 1'b1);
      end
      OP_TICK: begin
        popped = 0;
        while (timers.size() > 0 && timers[0].due < {1'b0, c.now_s}) begin
          e = timers.pop_front();
          post_report(ST_OK, 1'b1, e.tag, e.due, 1'b0);
          popped++;
        end
        if (popped == 0) post_report(ST_OK, 1'b0, '0, '0, 1'b1);
        else report_q[report_q.size() - 1].last = 1'b1;
      end
      default: post_report(ST_OK, 1'b0, '0, '0, 1'b1);
    endcase
  endfunction

  function automatic void check_field(string name, longint unsigned want, longint unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      failed = 1'b1;
    end
  endfunction

  function automatic void check_report();
    report_t want;
    if (report_q.size() == 0) begin
      $error("result beat with no expected result waiting");
      failed = 1'b1;
    end else begin
      want = report_q.pop_front();
      check_field("status", 64'(want.status), 64'(rsp_if.status));
      check_field("fired", 64'(want.fired), 64'(rsp_if.fired));
      check_field("fired_tag", 64'(want.tag), 64'(rsp_if.fired_tag));
      check_field("fired_time", 64'(want.when), 64'(rsp_if.fired_time));
      check_field("last", 64'(want.last), 64'(rsp_if.last));
      check_field("queue_count", 64'(want.count), 64'(rsp_if.queue_count));
      check_field("queue_empty", 64'(want.empty), 64'(rsp_if.queue_empty));
      check_field("next_due", 64'(want.next_due), 64'(rsp_if.next_due));
    end
  endfunction

  // command driver: hold the beat until taken, then wait out the next gap
  always @(negedge clk) begin
    if (rst) begin
      cmd_valid <= 1'b0;
    end else if (!(cmd_valid && n_cmd_taken != n_cmd_sent)) begin
      if (cmd_feed.size() > 0 && waited >= cmd_feed[0].gap) begin
        cur_cmd   <= cmd_feed.pop_front();
        cmd_valid <= 1'b1;
        n_cmd_sent++;
        waited = 0;
      end else begin
        if (cmd_feed.size() > 0) waited++;
        cmd_valid <= 1'b0;
      end
    end
  end

  // result stall: draw a fresh stall after each beat
  always @(negedge clk) begin
    if (n_beats != beats_seen) begin
      beats_seen = n_beats;
      stall = ((n_beats / 50) % 4 == 1) ? 0 : $urandom_range(0, 14);
    end
    if (stall > 0) begin
      stall--;
      res_ready <= 1'b0;
    end else begin
      res_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (cmd_valid && req_if.ready) begin
        n_cmd_taken++;
        apply_timer_cmd(cur_cmd);
      end
      if (rsp_if.valid && res_ready) begin
        n_beats++;
        check_report();
      end
    end
  end

  initial begin
    #10ms;
    $display("status: fail");
    $finish;
  end

  initial begin
    timer_cmd_t c;
    seg_kind_t  seg;
    int         seg_len, k, roll, adv, n_rand;
    logic [W_OP-1:0] op;

    sim_now = W_NOW_S'($urandom_range(0, 32'h3FFF_FFFF));

    c = timed_cmd(OP_TICK);   cmd_feed.push_back(c);
    c = timed_cmd(OP_REMOVE); c.pos = 1; cmd_feed.push_back(c);
    c.pos = 0;                cmd_feed.push_back(c);
    c = timed_cmd(OP_INSERT); c.rel = 0; c.pm = 0; c.tgt_h = 24; c.tgt_m = 0;
    cmd_feed.push_back(c);
    c.tgt_h = 0;  c.tgt_m = 60; cmd_feed.push_back(c);
    c.tgt_h = 63; c.tgt_m = 63; c.pm = 1; c.rel = 1; cmd_feed.push_back(c);
    c.tgt_h = 1;  c.tgt_m = 5;  cmd_feed.push_back(c);
    c.rel = 0; c.tgt_h = 11; c.tgt_m = 59; c.tag = 16'h0001; cmd_feed.push_back(c);
    c.pm = 0; c.rel = 1; c.tgt_h = 23; c.tgt_m = 59; c.tag = 16'hFFFF; cmd_feed.push_back(c);
    c.rel = 0; c.tgt_h = 0; c.tgt_m = 0; c.tag = 16'h0000; cmd_feed.push_back(c);
    c.tag = 16'h5A5A; cmd_feed.push_back(c);
    // minute borrow at the hour of now: wrap to 23 hours ahead
    c.now_h = 5; c.now_m = 30; c.tgt_h = 5; c.tgt_m = 10; c.tag = 16'h0F0F;
    cmd_feed.push_back(c);
    c.now_s = '0; c.now_sec = 63; c.rel = 1; c.tgt_h = 0; c.tgt_m = 0;
    cmd_feed.push_back(c);
    c.now_s = '1; c.now_h = 31; c.now_m = 63; c.now_sec = 0; c.rel = 0;
    cmd_feed.push_back(c);
    c = timed_cmd(OP_UNUSED); cmd_feed.push_back(c);
    c = timed_cmd(OP_REMOVE); c.pos = 0; cmd_feed.push_back(c);
    c.pos = 8'hFF; cmd_feed.push_back(c);
    c.pos = 7;     cmd_feed.push_back(c);
    c.pos = 1;     cmd_feed.push_back(c);
    sim_now = W_NOW_S'(sim_now + 200000);
    c = timed_cmd(OP_TICK); cmd_feed.push_back(c);
    cmd_feed.push_back(c);

    n_rand = 0;
    while (n_rand < RAND_ITEMS) begin
      seg       = seg_kind_t'($urandom_range(0, 2));
      seg_len   = $urandom_range(10, 30);
      stim_calm = ($urandom_range(0, 3) == 0);
      for (k = 0; k < seg_len; k++) begin
        roll = $urandom_range(0, 99);
        case (seg)
          SEG_FILL: begin
            op  = (roll < 90) ? OP_INSERT : OP_TICK;
            adv = $urandom_range(0, 60);
          end
          SEG_CHURN: begin
            op  = (roll < 40) ? OP_INSERT : (roll < 75) ? OP_TICK
                : (roll < 90) ? OP_REMOVE : OP_UNUSED;
            adv = $urandom_range(0, 3000);
          end
          default: begin
            op  = (roll < 60) ? OP_TICK : (roll < 90) ? OP_REMOVE : OP_INSERT;
            adv = $urandom_range(0, 20000);
          end
        endcase
        sim_now = W_NOW_S'(sim_now + adv);
        // unused code in churn stands for a fully random beat
        c = (op == OP_UNUSED) ? noise_cmd() : timed_cmd(op);
        cmd_feed.push_back(c);
        n_rand++;
      end
    end
    n_total = cmd_feed.size();

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    wait (n_cmd_taken == n_total);
    while (report_q.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    if (!failed) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
